FILE: hdl/fop_pkg.sv
// Shared types, constants and helpers for the flux observer / PLL estimator.
// Used by fop_ctrl, fop_dp and flux_observer_pll_unit; no dependencies.
package fop_pkg;

  localparam logic [2:0] RegStatorRes  = 3'd0;
  localparam logic [2:0] RegStatorInd  = 3'd1;
  localparam logic [2:0] RegFluxLink   = 3'd2;
  localparam logic [2:0] RegPllProp    = 3'd3;
  localparam logic [2:0] RegPllInt     = 3'd4;
  localparam logic [2:0] RegObsGain    = 3'd5;
  localparam logic [2:0] RegStepTime   = 3'd6;

  localparam logic [15:0] StatorResReset = 16'd410;
  localparam logic [23:0] StatorIndReset = 24'd168;
  localparam logic [23:0] FluxLinkReset  = 24'd83886;
  localparam logic [31:0] PllPropReset   = 32'd131072000;
  localparam logic [31:0] PllIntReset    = 32'd10240000;
  localparam logic [31:0] ObsGainReset   = 32'd64000000;
  localparam logic [31:0] StepTimeReset  = 32'd214748;

  localparam logic signed [33:0] TwoPiQ29    = 34'sd3373259426;
  localparam logic signed [33:0] InvTwoPiQ24 = 34'sd2670177;

  typedef struct packed {
    logic [15:0] stator_resistance;
    logic [23:0] stator_inductance;
    logic [23:0] flux_linkage;
    logic [31:0] pll_prop_gain;
    logic [31:0] pll_int_gain;
    logic [31:0] observer_gain;
    logic [31:0] step_time;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_RESTART, OP_LA, OP_LB, OP_E, OP_LL, OP_SA, OP_SB,
    OP_ERR, OP_G, OP_XA1, OP_XA2, OP_FA, OP_XB1, OP_XB2, OP_FB, OP_CP, OP_CI,
    OP_D, OP_T, OP_W, OP_P, OP_M1, OP_M2, OP_K, OP_T2, OP_SP, OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [4:0] iter;
  } dp_cmd_t;

  typedef struct packed {
    logic vec_zero;
  } dp_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
    if (v > 70'sd2147483647) begin
      return 32'sd2147483647;
    end else if (v < -70'sd2147483647) begin
      return -32'sd2147483647;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/fop_ctrl.sv
// Sequencer for the estimator: walks the datapath through one sample, runs the
// CORDIC iterations and owns the input and result handshakes. Depends on fop_pkg.
module fop_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            cmd_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output fop_pkg::dp_cmd_t dp_cmd_o,
  input  fop_pkg::dp_sts_t dp_sts_i
);
  import fop_pkg::*;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_LA   = 5'd1;
  localparam logic [4:0] ST_LB   = 5'd2;
  localparam logic [4:0] ST_E1   = 5'd3;
  localparam logic [4:0] ST_LL   = 5'd4;
  localparam logic [4:0] ST_SA   = 5'd5;
  localparam logic [4:0] ST_SB   = 5'd6;
  localparam logic [4:0] ST_ERR  = 5'd7;
  localparam logic [4:0] ST_G    = 5'd8;
  localparam logic [4:0] ST_XA1  = 5'd9;
  localparam logic [4:0] ST_XA2  = 5'd10;
  localparam logic [4:0] ST_FA   = 5'd11;
  localparam logic [4:0] ST_XB1  = 5'd12;
  localparam logic [4:0] ST_XB2  = 5'd13;
  localparam logic [4:0] ST_FB   = 5'd14;
  localparam logic [4:0] ST_E2   = 5'd15;
  localparam logic [4:0] ST_CP   = 5'd16;
  localparam logic [4:0] ST_CI   = 5'd17;
  localparam logic [4:0] ST_D    = 5'd18;
  localparam logic [4:0] ST_T    = 5'd19;
  localparam logic [4:0] ST_W    = 5'd20;
  localparam logic [4:0] ST_P    = 5'd21;
  localparam logic [4:0] ST_M1   = 5'd22;
  localparam logic [4:0] ST_M2   = 5'd23;
  localparam logic [4:0] ST_K    = 5'd24;
  localparam logic [4:0] ST_T2   = 5'd25;
  localparam logic [4:0] ST_SP   = 5'd26;
  localparam logic [4:0] ST_DONE = 5'd27;
  localparam logic [4:0] ST_RST  = 5'd28;

  logic [4:0] state_q, state_d;
  logic [4:0] iter_q, iter_d;
  logic       out_valid_q, out_valid_d;
  logic       load;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign load        = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    iter_d      = iter_q;
    dp_cmd_o.op = OP_NONE;
    dp_cmd_o.iter = iter_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          dp_cmd_o.op = OP_CAPTURE;
          state_d = cmd_i ? ST_RST : ST_LA;
        end
      end
      ST_RST: begin dp_cmd_o.op = OP_RESTART; state_d = ST_DONE; end
      ST_LA:  begin dp_cmd_o.op = OP_LA;  state_d = ST_LB;  end
      ST_LB:  begin dp_cmd_o.op = OP_LB;  state_d = ST_E1;  end
      ST_E1:  begin dp_cmd_o.op = OP_E;   state_d = ST_LL;  end
      ST_LL:  begin dp_cmd_o.op = OP_LL;  state_d = ST_SA;  end
      ST_SA:  begin dp_cmd_o.op = OP_SA;  state_d = ST_SB;  end
      ST_SB:  begin dp_cmd_o.op = OP_SB;  state_d = ST_ERR; end
      ST_ERR: begin dp_cmd_o.op = OP_ERR; state_d = ST_G;   end
      ST_G:   begin dp_cmd_o.op = OP_G;   state_d = ST_XA1; end
      ST_XA1: begin dp_cmd_o.op = OP_XA1; state_d = ST_XA2; end
      ST_XA2: begin dp_cmd_o.op = OP_XA2; state_d = ST_FA;  end
      ST_FA:  begin dp_cmd_o.op = OP_FA;  state_d = ST_XB1; end
      ST_XB1: begin dp_cmd_o.op = OP_XB1; state_d = ST_XB2; end
      ST_XB2: begin dp_cmd_o.op = OP_XB2; state_d = ST_FB;  end
      ST_FB:  begin dp_cmd_o.op = OP_FB;  state_d = ST_E2;  end
      ST_E2:  begin dp_cmd_o.op = OP_E;   state_d = ST_CP;  end
      ST_CP: begin
        dp_cmd_o.op = OP_CP;
        iter_d = '0;
        state_d = ST_CI;
      end
      ST_CI: begin
        if (dp_sts_i.vec_zero) begin
          state_d = ST_D;
        end else begin
          dp_cmd_o.op = OP_CI;
          iter_d = iter_q + 5'd1;
          if (iter_q == 5'(CORDIC_STEPS - 1)) begin
            state_d = ST_D;
          end
        end
      end
      ST_D:   begin dp_cmd_o.op = OP_D;   state_d = ST_T;   end
      ST_T:   begin dp_cmd_o.op = OP_T;   state_d = ST_W;   end
      ST_W:   begin dp_cmd_o.op = OP_W;   state_d = ST_P;   end
      ST_P:   begin dp_cmd_o.op = OP_P;   state_d = ST_M1;  end
      ST_M1:  begin dp_cmd_o.op = OP_M1;  state_d = ST_M2;  end
      ST_M2:  begin dp_cmd_o.op = OP_M2;  state_d = ST_K;   end
      ST_K:   begin dp_cmd_o.op = OP_K;   state_d = ST_T2;  end
      ST_T2:  begin dp_cmd_o.op = OP_T2;  state_d = ST_SP;  end
      ST_SP:  begin dp_cmd_o.op = OP_SP;  state_d = ST_DONE; end
      ST_DONE: begin
        if (load) begin
          dp_cmd_o.op = OP_OUT;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hdl/fop_dp.sv
// Datapath of the estimator: one shared signed multiplier, flux and PLL state,
// the iterative CORDIC and the result register. Depends on fop_pkg.
module fop_dp #(
  parameter int FLUX_FRAC_BITS = 28
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fop_pkg::cfg_t       cfg_i,
  input  fop_pkg::dp_cmd_t    cmd_i,
  output fop_pkg::dp_sts_t    sts_o,
  input  logic signed [15:0]  v_alpha_i,
  input  logic signed [15:0]  v_beta_i,
  input  logic signed [15:0]  i_alpha_i,
  input  logic signed [15:0]  i_beta_i,
  output logic [15:0]         rotor_angle_o,
  output logic signed [31:0]  rotor_speed_o
);
  import fop_pkg::*;

  localparam logic [31:0] LamReset = {FluxLinkReset, 8'h00} >> (32 - FLUX_FRAC_BITS);

  logic signed [33:0] op_a, op_b;
  logic signed [67:0] prod;
  logic [31:0]        lam;
  logic signed [65:0] sum_w;
  logic signed [35:0] xs, ys;

  logic signed [15:0] va_q, vb_q, ia_q, ib_q, va_d, vb_d, ia_d, ib_d;
  logic signed [39:0] la_q, lb_q, la_d, lb_d, p_q, p_d;
  logic signed [31:0] e1_q, e2_q, e1_d, e2_d, err_q, err_d, g_q, g_d, x_q, x_d;
  logic signed [31:0] d_q, d_d, t_q, t_d, w_q, w_d;
  logic signed [65:0] acc_q, acc_d;
  logic signed [35:0] cx_q, cy_q, cx_d, cy_d;
  logic [31:0]        ang_q, ang_d, k_q, k_d;
  logic signed [31:0] flux_a_q, flux_a_d, flux_b_q, flux_b_d, speed_q, speed_d;
  logic [31:0]        pll_q, pll_d;
  logic [15:0]        angle_out_q, angle_out_d;
  logic signed [31:0] speed_out_q, speed_out_d;

  assign lam   = {cfg_i.flux_linkage, 8'h00} >> (32 - FLUX_FRAC_BITS);
  assign prod  = op_a * op_b;
  assign sum_w = (66'(prod) <<< 20) + acc_q;
  assign xs    = cx_q >>> cmd_i.iter;
  assign ys    = cy_q >>> cmd_i.iter;
  assign sts_o.vec_zero = (e1_q == 32'sd0) && (e2_q == 32'sd0);

  assign rotor_angle_o = angle_out_q;
  assign rotor_speed_o = speed_out_q;

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (cmd_i.op)
      OP_LA:  begin op_a = signed'({10'd0, cfg_i.stator_inductance}); op_b = 34'(ia_q); end
      OP_LB:  begin op_a = signed'({10'd0, cfg_i.stator_inductance}); op_b = 34'(ib_q); end
      OP_LL:  begin op_a = signed'({2'd0, lam}); op_b = signed'({2'd0, lam}); end
      OP_SA:  begin op_a = 34'(e1_q); op_b = 34'(e1_q); end
      OP_SB:  begin op_a = 34'(e2_q); op_b = 34'(e2_q); end
      OP_G:   begin op_a = signed'({2'd0, cfg_i.observer_gain}); op_b = 34'(err_q); end
      OP_XA1: begin op_a = signed'({18'd0, cfg_i.stator_resistance}); op_b = 34'(ia_q); end
      OP_XB1: begin op_a = signed'({18'd0, cfg_i.stator_resistance}); op_b = 34'(ib_q); end
      OP_XA2: begin op_a = 34'(g_q); op_b = 34'(e1_q); end
      OP_XB2: begin op_a = 34'(g_q); op_b = 34'(e2_q); end
      OP_FA, OP_FB: begin op_a = 34'(x_q); op_b = signed'({2'd0, cfg_i.step_time}); end
      OP_T:   begin op_a = signed'({2'd0, cfg_i.pll_prop_gain}); op_b = 34'(d_q); end
      OP_W, OP_SP: begin op_a = 34'(t_q); op_b = TwoPiQ29; end
      OP_P:   begin op_a = 34'(w_q); op_b = signed'({2'd0, cfg_i.step_time}); end
      OP_M1:  begin op_a = signed'({14'd0, p_q[19:0]}); op_b = InvTwoPiQ24; end
      OP_M2:  begin op_a = 34'(p_q >>> 20); op_b = InvTwoPiQ24; end
      OP_K:   begin
        op_a = signed'({2'd0, cfg_i.pll_int_gain});
        op_b = signed'({2'd0, cfg_i.step_time});
      end
      OP_T2:  begin op_a = signed'({2'd0, k_q}); op_b = 34'(d_q); end
      default: ;
    endcase
  end

  always_comb begin
    va_d = va_q; vb_d = vb_q; ia_d = ia_q; ib_d = ib_q;
    la_d = la_q; lb_d = lb_q; p_d = p_q;
    e1_d = e1_q; e2_d = e2_q; err_d = err_q; g_d = g_q; x_d = x_q;
    d_d = d_q; t_d = t_q; w_d = w_q; acc_d = acc_q;
    cx_d = cx_q; cy_d = cy_q; ang_d = ang_q; k_d = k_q;
    flux_a_d = flux_a_q; flux_b_d = flux_b_q; speed_d = speed_q; pll_d = pll_q;
    angle_out_d = angle_out_q; speed_out_d = speed_out_q;
    unique case (cmd_i.op)
      OP_CAPTURE: begin
        va_d = v_alpha_i; vb_d = v_beta_i; ia_d = i_alpha_i; ib_d = i_beta_i;
      end
      OP_RESTART: begin
        flux_a_d = signed'(lam);
        flux_b_d = '0;
        pll_d    = '0;
        speed_d  = '0;
        ang_d    = '0;
      end
      OP_LA: la_d = 40'(prod >>> (32 - FLUX_FRAC_BITS));
      OP_LB: lb_d = 40'(prod >>> (32 - FLUX_FRAC_BITS));
      OP_E: begin
        e1_d = sat32(70'(flux_a_q) - 70'(la_q));
        e2_d = sat32(70'(flux_b_q) - 70'(lb_q));
      end
      OP_LL: acc_d = 66'(prod);
      OP_SA, OP_SB: acc_d = acc_q - 66'(prod);
      OP_ERR: err_d = sat32(70'(acc_q >>> (2 * FLUX_FRAC_BITS - 32)));
      OP_G: g_d = sat32(70'(prod >>> 24));
      OP_XA1: acc_d = (66'(va_q) <<< 8) - 66'(prod >>> 4);
      OP_XB1: acc_d = (66'(vb_q) <<< 8) - 66'(prod >>> 4);
      OP_XA2, OP_XB2: x_d = sat32(70'(acc_q) + 70'(prod >>> (FLUX_FRAC_BITS + 1)));
      OP_FA: flux_a_d = sat32(70'(flux_a_q) + 70'(prod >>> (48 - FLUX_FRAC_BITS)));
      OP_FB: flux_b_d = sat32(70'(flux_b_q) + 70'(prod >>> (48 - FLUX_FRAC_BITS)));
      OP_CP: begin
        if (e1_q < 32'sd0) begin
          cx_d  = -36'(e1_q);
          cy_d  = -36'(e2_q);
          ang_d = 32'h8000_0000;
        end else begin
          cx_d  = 36'(e1_q);
          cy_d  = 36'(e2_q);
          ang_d = '0;
        end
      end
      OP_CI: begin
        if (cy_q >= 36'sd0) begin
          cx_d  = cx_q + ys;
          cy_d  = cy_q - xs;
          ang_d = ang_q + atan_turn(cmd_i.iter);
        end else begin
          cx_d  = cx_q - ys;
          cy_d  = cy_q + xs;
          ang_d = ang_q - atan_turn(cmd_i.iter);
        end
      end
      OP_D: d_d = signed'(ang_q - pll_q);
      OP_T, OP_T2: t_d = sat32(70'(prod >>> 32));
      OP_W: w_d = sat32(70'(speed_q) + 70'(prod >>> 29));
      OP_P: p_d = 40'(prod >>> 24);
      OP_M1: acc_d = 66'(prod);
      OP_M2: pll_d = pll_q + sum_w[47:16];
      OP_K: k_d = (|prod[67:56]) ? 32'hFFFF_FFFF : prod[55:24];
      OP_SP: speed_d = sat32(70'(speed_q) + 70'(prod >>> 29));
      OP_OUT: begin
        angle_out_d = ang_q[31:16];
        speed_out_d = speed_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flux_a_q <= signed'(LamReset);
      flux_b_q <= '0;
      pll_q    <= '0;
      speed_q  <= '0;
    end else begin
      flux_a_q <= flux_a_d;
      flux_b_q <= flux_b_d;
      pll_q    <= pll_d;
      speed_q  <= speed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    va_q <= va_d; vb_q <= vb_d; ia_q <= ia_d; ib_q <= ib_d;
    la_q <= la_d; lb_q <= lb_d; p_q <= p_d;
    e1_q <= e1_d; e2_q <= e2_d; err_q <= err_d; g_q <= g_d; x_q <= x_d;
    d_q <= d_d; t_q <= t_d; w_q <= w_d; acc_q <= acc_d;
    cx_q <= cx_d; cy_q <= cy_d; ang_q <= ang_d; k_q <= k_d;
    angle_out_q <= angle_out_d;
    speed_out_q <= speed_out_d;
  end

endmodule

FILE: hdl/flux_observer_pll_unit.sv
// Top level of the sensorless flux observer with PLL: configuration registers,
// sequencer and datapath. Depends on fop_pkg, fop_ctrl and fop_dp.
//
//   port group   direction  handshake              payload
//   input        in         in_valid_i/in_stall_o  cmd_i, v_alpha_i, v_beta_i, i_alpha_i, i_beta_i
//   result       out        out_valid_o/out_stall_i rotor_angle_o, rotor_speed_o
//   config       in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// An update steps the shared multiplier through the sample, then the CORDIC iterates once
// a cycle up to CORDIC_STEPS times; with zero rotor flux the CORDIC iterations are skipped,
// and a restart skips the update and only reloads the flux, PLL and speed state.
// One item is worked on at a time; a new one is taken while the previous result waits
// in the output register. Reset loads the register defaults and the restart state.
// A stalled result holds the sequencer at its end.
module flux_observer_pll_unit #(
  parameter int CORDIC_STEPS   = 16,
  parameter int FLUX_FRAC_BITS = 28
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic signed [15:0] v_alpha_i,
  input  logic signed [15:0] v_beta_i,
  input  logic signed [15:0] i_alpha_i,
  input  logic signed [15:0] i_beta_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        rotor_angle_o,
  output logic signed [31:0] rotor_speed_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import fop_pkg::*;

  cfg_t    cfg_q, cfg_d;
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegStatorRes: cfg_d.stator_resistance = cfg_data_i[15:0];
        RegStatorInd: cfg_d.stator_inductance = cfg_data_i[23:0];
        RegFluxLink:  cfg_d.flux_linkage      = cfg_data_i[23:0];
        RegPllProp:   cfg_d.pll_prop_gain     = cfg_data_i;
        RegPllInt:    cfg_d.pll_int_gain      = cfg_data_i;
        RegObsGain:   cfg_d.observer_gain     = cfg_data_i;
        RegStepTime:  cfg_d.step_time         = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stator_resistance <= StatorResReset;
      cfg_q.stator_inductance <= StatorIndReset;
      cfg_q.flux_linkage      <= FluxLinkReset;
      cfg_q.pll_prop_gain     <= PllPropReset;
      cfg_q.pll_int_gain      <= PllIntReset;
      cfg_q.observer_gain     <= ObsGainReset;
      cfg_q.step_time         <= StepTimeReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  fop_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .dp_cmd_o   (dp_cmd),
    .dp_sts_i   (dp_sts)
  );

  fop_dp #(
    .FLUX_FRAC_BITS(FLUX_FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_i        (dp_cmd),
    .sts_o        (dp_sts),
    .v_alpha_i    (v_alpha_i),
    .v_beta_i     (v_beta_i),
    .i_alpha_i    (i_alpha_i),
    .i_beta_i     (i_beta_i),
    .rotor_angle_o(rotor_angle_o),
    .rotor_speed_o(rotor_speed_o)
  );

endmodule
